[hdl/indexed_sequential_search_defines.svh]
// Assertion macros for the indexed sequential search block.
// Included by the RTL files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef INDEXED_SEQUENTIAL_SEARCH_DEFINES_SVH
`define INDEXED_SEQUENTIAL_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
`define ISS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ISS_ASSERT_NORST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ISS_ASSERT(lbl, prop, msg)
`define ISS_ASSERT_NORST(lbl, prop, msg)
`endif

`endif

[hdl/iss_pkg.sv]
// Shared types and codes of the indexed sequential search block.
// No dependencies; used by iss_ctrl and indexed_sequential_search.
package iss_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  localparam logic [1:0] ORD_ASC  = 2'd0;
  localparam logic [1:0] ORD_DESC = 2'd1;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_REFUSED   = 2'd2;

  localparam logic CFG_PAGE_SIZE  = 1'b0;
  localparam logic CFG_ORDER_MODE = 1'b1;

  typedef struct packed {
    logic [6:0] page_size;
    logic [1:0] order_mode;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } res_t;

endpackage

[hdl/indexed_sequential_search.sv]
// Channel      Dir  tdata                                  tuser
// s_axis       in   [31:0] record_key, [63:32] record_payload  [1:0] operation
// m_axis       out  [31:0] found_key, [63:32] found_payload    [1:0] search_status
// cfg          in   cfg_idx_i 0 page_size, 1 order_mode; cfg_data_i [6:0]
// Clear and append give no result word.
// A search scans the pages of the index at one key RAM read per cycle, then runs binary
// probes within the chosen page, each a read state and then a compare state on the
// single read port.
// Reset empties the store at once; RAM contents need no clearing pass.
// A result waits in the output register while the next word is taken.
`include "indexed_sequential_search_defines.svh"

module indexed_sequential_search #(
  parameter int MAX_RECORDS = 1024,
  parameter int MAX_PAGES   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // record_key [31:0], record_payload [63:32]
  input  logic [1:0]  s_axis_tuser,   // operation [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // found_key [31:0], found_payload [63:32]
  output logic [1:0]  m_axis_tuser,   // search_status [1:0]
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);

  iss_pkg::cfg_t cfg_q;
  iss_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;
  logic          m_valid_q;
  logic [63:0]   m_data_q;
  logic [1:0]    m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.page_size  <= 7'd8;
      cfg_q.order_mode <= iss_pkg::ORD_ASC;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        iss_pkg::CFG_PAGE_SIZE:  cfg_q.page_size  <= cfg_data_i;
        iss_pkg::CFG_ORDER_MODE: cfg_q.order_mode <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  iss_ctrl #(
    .MAX_RECORDS (MAX_RECORDS),
    .MAX_PAGES   (MAX_PAGES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_key_i    (s_axis_tdata[31:0]),
    .in_pay_i    (s_axis_tdata[63:32]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      m_data_q <= {res.payload, res.key};
      m_user_q <= res.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  `ISS_ASSERT(a_out_hold, (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(m_data_q)), "output word dropped while stalled")
  `ISS_ASSERT(a_miss_zero, (m_valid_q && m_user_q != iss_pkg::ST_FOUND) |-> (m_data_q == '0), "unmatched result carries data")
  `ISS_ASSERT(a_status_code, m_valid_q |-> (m_user_q == iss_pkg::ST_FOUND || m_user_q == iss_pkg::ST_NOT_FOUND || m_user_q == iss_pkg::ST_REFUSED), "bad status code")

endmodule

[hdl/iss_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module iss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/iss_ctrl.sv]
// Record store, page index scan and binary search sequencer.
// Depends on iss_pkg, iss_ram and indexed_sequential_search_defines.svh.
`include "indexed_sequential_search_defines.svh"

module iss_ctrl #(
  parameter int MAX_RECORDS = 1024,
  parameter int MAX_PAGES   = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iss_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_op_i,
  input  logic signed [31:0] in_key_i,
  input  logic [31:0]        in_pay_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output iss_pkg::res_t      res_o
);

  localparam int AW  = $clog2(MAX_RECORDS);
  localparam int CW  = $clog2(MAX_RECORDS + 1);
  localparam int SW  = $clog2(MAX_RECORDS + 65);
  localparam int PGW = $clog2(MAX_PAGES + 1);
  localparam int LW  = PGW + 7;
  localparam int MW  = (CW > LW) ? CW : LW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BIN_RD,
    S_BIN_CHK,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [31:0] key_q, key_d;
  logic               desc_q, desc_d;
  logic [6:0]         ps_q, ps_d;
  logic [SW-1:0]      iss_addr_q, iss_addr_d;
  logic [PGW-1:0]     iss_pg_q, iss_pg_d;
  logic               pend_q, pend_d;
  logic [SW-1:0]      chk_addr_q, chk_addr_d;
  logic               have_q, have_d;
  logic [AW-1:0]      best_q, best_d;
  logic [AW-1:0]      first_q, first_d;
  logic [6:0]         lo_q, lo_d;
  logic signed [7:0]  hi_q, hi_d;
  logic [6:0]         mid_q, mid_d;
  iss_pkg::res_t      res_q, res_d;

  logic [6:0]         ps_eff;
  logic [LW-1:0]      page_lim;
  logic               in_fire;
  logic               room;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] key_rdata;
  logic [31:0]        pay_rdata;
  logic               can_issue;
  logic               hit;
  logic [MW-1:0]      rem_w;
  logic [6:0]         cnt_pg;
  logic [7:0]         mid_sum;
  logic [6:0]         mid_c;
  logic               go_right;
  logic [6:0]         lo_n;
  logic signed [7:0]  hi_n;

  always_comb begin
    if (cfg_i.page_size == 7'd0) begin
      ps_eff = 7'd1;
    end else if (cfg_i.page_size > 7'd64) begin
      ps_eff = 7'd64;
    end else begin
      ps_eff = cfg_i.page_size;
    end
  end

  assign page_lim   = LW'(MAX_PAGES) * LW'(ps_eff);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign room       = (MW'(cnt_q) < MW'(MAX_RECORDS)) && (MW'(cnt_q) < MW'(page_lim));
  assign wr_en      = in_fire && (in_op_i == iss_pkg::OP_APPEND) && room;

  assign can_issue = (iss_addr_q < SW'(cnt_q)) && (iss_pg_q < PGW'(MAX_PAGES));
  assign hit       = pend_q && (desc_q ? (key_rdata >= key_q) : (key_rdata <= key_q));
  assign rem_w     = MW'(cnt_q) - MW'(best_q);
  assign cnt_pg    = (rem_w > MW'(ps_q)) ? ps_q : rem_w[6:0];

  assign mid_sum  = {1'b0, lo_q} + hi_q;
  assign mid_c    = mid_sum[7:1];
  assign go_right = desc_q ? (key_rdata > key_q) : (key_rdata < key_q);
  assign lo_n     = go_right ? (mid_q + 7'd1) : lo_q;
  assign hi_n     = go_right ? hi_q : ($signed({1'b0, mid_q}) - 8'sd1);

  assign rd_addr = (state_q == S_SCAN) ? iss_addr_q[AW-1:0] : (first_q + AW'(mid_c));

  iss_ram #(.WIDTH(32), .DEPTH(MAX_RECORDS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_key_i),
    .raddr_i (rd_addr),
    .rdata_o (key_rdata)
  );

  iss_ram #(.WIDTH(32), .DEPTH(MAX_RECORDS)) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_pay_i),
    .raddr_i (rd_addr),
    .rdata_o (pay_rdata)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    key_d      = key_q;
    desc_d     = desc_q;
    ps_d       = ps_q;
    iss_addr_d = iss_addr_q;
    iss_pg_d   = iss_pg_q;
    pend_d     = pend_q;
    chk_addr_d = chk_addr_q;
    have_d     = have_q;
    best_d     = best_q;
    first_d    = first_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    res_d      = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_op_i)
            iss_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            iss_pkg::OP_APPEND: begin
              if (room) begin
                cnt_d = cnt_q + CW'(1);
              end
            end
            iss_pkg::OP_SEARCH: begin
              key_d      = in_key_i;
              desc_d     = (cfg_i.order_mode == iss_pkg::ORD_DESC);
              ps_d       = ps_eff;
              iss_addr_d = '0;
              iss_pg_d   = '0;
              pend_d     = 1'b0;
              have_d     = 1'b0;
              if ((cfg_i.order_mode == iss_pkg::ORD_ASC) ||
                  (cfg_i.order_mode == iss_pkg::ORD_DESC)) begin
                state_d = S_SCAN;
              end else begin
                res_d   = '{status: iss_pkg::ST_REFUSED, key: '0, payload: '0};
                state_d = S_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if ((pend_q && !hit) || (!pend_q && !can_issue)) begin
          pend_d = 1'b0;
          if (have_q) begin
            first_d = best_q;
            lo_d    = '0;
            hi_d    = $signed({1'b0, cnt_pg}) - 8'sd1;
            state_d = S_BIN_RD;
          end else begin
            res_d   = '{status: iss_pkg::ST_NOT_FOUND, key: '0, payload: '0};
            state_d = S_DONE;
          end
        end else begin
          if (hit) begin
            have_d = 1'b1;
            best_d = chk_addr_q[AW-1:0];
          end
          pend_d = can_issue;
          if (can_issue) begin
            chk_addr_d = iss_addr_q;
            iss_addr_d = iss_addr_q + SW'(ps_q);
            iss_pg_d   = iss_pg_q + PGW'(1);
          end
        end
      end
      S_BIN_RD: begin
        mid_d   = mid_c;
        state_d = S_BIN_CHK;
      end
      S_BIN_CHK: begin
        if (key_rdata == key_q) begin
          res_d   = '{status: iss_pkg::ST_FOUND, key: key_q, payload: pay_rdata};
          state_d = S_DONE;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          if ($signed({1'b0, lo_n}) <= hi_n) begin
            state_d = S_BIN_RD;
          end else begin
            res_d   = '{status: iss_pkg::ST_NOT_FOUND, key: '0, payload: '0};
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      key_q      <= '0;
      desc_q     <= 1'b0;
      ps_q       <= '0;
      iss_addr_q <= '0;
      iss_pg_q   <= '0;
      pend_q     <= 1'b0;
      chk_addr_q <= '0;
      have_q     <= 1'b0;
      best_q     <= '0;
      first_q    <= '0;
      lo_q       <= '0;
      hi_q       <= '0;
      mid_q      <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      key_q      <= key_d;
      desc_q     <= desc_d;
      ps_q       <= ps_d;
      iss_addr_q <= iss_addr_d;
      iss_pg_q   <= iss_pg_d;
      pend_q     <= pend_d;
      chk_addr_q <= chk_addr_d;
      have_q     <= have_d;
      best_q     <= best_d;
      first_q    <= first_d;
      lo_q       <= lo_d;
      hi_q       <= hi_d;
      mid_q      <= mid_d;
      res_q      <= res_d;
    end
  end

  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  `ISS_ASSERT(a_clear_empties, (in_fire && in_op_i == iss_pkg::OP_CLEAR) |=> (cnt_q == '0), "clear did not empty the store")
  `ISS_ASSERT(a_append_counts, wr_en |=> (cnt_q == CW'($past(cnt_q) + CW'(1))), "append did not advance the record count")
  `ISS_ASSERT(a_scan_in_range, (state_q == S_SCAN && pend_q) |-> (chk_addr_q < SW'(cnt_q)), "page scan read past the filled records")
  `ISS_ASSERT(a_probe_in_page, (state_q == S_BIN_RD) |-> ($signed({1'b0, lo_q}) <= hi_q), "binary probe with an empty interval")

endmodule

[test/tb_indexed_sequential_search.sv]
`timescale 1ns / 1ps
// Self-checking testbench for indexed_sequential_search: streams clear, append and search
// words, predicts every search result from its own copy of the record file and checks the
// result stream. Depends on iss_pkg and the indexed_sequential_search RTL.
module tb_indexed_sequential_search;

  localparam int         FILE_DEPTH    = 1024;
  localparam int         INDEX_DEPTH   = 256;
  localparam int         MAX_GAP       = 11;
  localparam int         SETTLE        = 300;
  localparam int         RANDOM_WORDS  = 600;
  localparam int         TAIL_WORDS    = 120;
  localparam int         PRINT_CAP     = 40;
  localparam longint     CYCLE_LIMIT   = 4_000_000;
  localparam logic [1:0] OP_NOP        = 2'd3;
  localparam logic [1:0] ORD_UNORDERED = 2'd2;
  localparam logic [1:0] ORD_INVALID   = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // record_key [31:0], record_payload [63:32]
  logic [1:0]  s_axis_tuser;   // operation [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // found_key [31:0], found_payload [63:32]
  logic [1:0]  m_axis_tuser;   // search_status [1:0]
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [6:0]  cfg_data_i;

  logic signed [31:0] file_keys [FILE_DEPTH];
  logic [31:0]        file_payloads [FILE_DEPTH];
  int                 file_count;
  logic [6:0]         page_size_reg;
  logic [1:0]         order_reg;
  iss_pkg::res_t      pending_results [$];

  int     mismatches;
  int     words_sent;
  int     searches_checked;
  int     settings_used;
  bit     idle_on;
  longint cycles;

  indexed_sequential_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  function automatic int page_len();
    if (page_size_reg == 7'd0) return 1;
    if (page_size_reg > 7'd64) return 64;
    return int'(page_size_reg);
  endfunction

  function automatic bit not_past(input logic signed [31:0] a, input logic signed [31:0] b,
                                  input bit desc);
    return desc ? (a >= b) : (a <= b);
  endfunction

  function automatic iss_pkg::res_t search_file(input logic signed [31:0] key);
    iss_pkg::res_t r;
    int            ps;
    int            pages;
    int            i;
    int            first;
    int            span;
    int            lo;
    int            hi;
    int            mid;
    bit            desc;
    r.status  = iss_pkg::ST_NOT_FOUND;
    r.key     = '0;
    r.payload = '0;
    if (order_reg == ORD_UNORDERED || order_reg == ORD_INVALID) begin
      r.status = iss_pkg::ST_REFUSED;
      return r;
    end
    desc  = (order_reg == iss_pkg::ORD_DESC);
    ps    = page_len();
    pages = (file_count + ps - 1) / ps;
    if (pages > INDEX_DEPTH) pages = INDEX_DEPTH;
    i = 0;
    while (i < pages && not_past(file_keys[i * ps], key, desc)) i++;
    if (i == 0) return r;
    first = (i - 1) * ps;
    span  = file_count - first;
    if (span > ps) span = ps;
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (file_keys[first + mid] == key) begin
        r.status  = iss_pkg::ST_FOUND;
        r.key     = key;
        r.payload = file_payloads[first + mid];
        return r;
      end
      if (desc ? (file_keys[first + mid] > key) : (file_keys[first + mid] < key)) lo = mid + 1;
      else hi = mid - 1;
    end
    return r;
  endfunction

  function automatic void apply_word(input logic [1:0] op, input logic signed [31:0] key,
                                     input logic [31:0] pay);
    case (op)
      iss_pkg::OP_CLEAR: file_count = 0;
      iss_pkg::OP_APPEND: begin
        if (file_count < FILE_DEPTH && file_count / page_len() < INDEX_DEPTH) begin
          file_keys[file_count]     = key;
          file_payloads[file_count] = pay;
          file_count++;
        end
      end
      iss_pkg::OP_SEARCH: pending_results.push_back(search_file(key));
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PRINT_CAP)
      $display("mismatch on %s at search %0d: got %h, expected %h", what, searches_checked,
               got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] key,
                           input logic [31:0] pay);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pay, key};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_word(op, key, pay);
    if (op != OP_NOP) words_sent++;
  endtask

  // hold the sender until every expected result is back and the block has gone quiet
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(input logic [6:0] ps, input logic [1:0] order);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= iss_pkg::CFG_PAGE_SIZE;
    cfg_data_i <= ps;
    @(posedge clk_i);
    page_size_reg = ps;
    cfg_idx_i  <= iss_pkg::CFG_ORDER_MODE;
    cfg_data_i <= {5'd0, order};
    @(posedge clk_i);
    order_reg = order;
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic append_run(input int n, input bit desc, input bit scrambled);
    logic signed [31:0] run [$];
    longint             stride;
    longint             cur;
    if (n <= 0) return;
    stride = 64'h1_0000_0000 / (n + 1);
    if ($urandom_range(0, 3) == 0 && stride > 4) stride = 4;
    cur = -(longint'(1) << 31) + $urandom_range(0, stride - 1);
    for (int i = 0; i < n; i++) begin
      run.push_back(scrambled ? $urandom : cur[31:0]);
      cur += ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, stride);
    end
    for (int i = 0; i < n; i++)
      send_word(iss_pkg::OP_APPEND, run[desc ? n - 1 - i : i], $urandom);
  endtask

  function automatic logic signed [31:0] pick_key();
    int                 r;
    logic signed [31:0] k;
    r = $urandom_range(0, 11);
    if (file_count == 0 || r == 11) return $urandom;
    if (r == 10) return ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    k = file_keys[$urandom_range(0, file_count - 1)];
    if (r < 6) return k;
    if (r < 8) return k + 1;
    return k - 1;
  endfunction

  task automatic test_edge_cases();
    configure(7'd4, iss_pkg::ORD_ASC);
    send_word(iss_pkg::OP_CLEAR, 0, 0);
    send_word(iss_pkg::OP_SEARCH, 0, 0);
    send_word(iss_pkg::OP_APPEND, 32'sh8000_0000, 32'h0000_0000);
    send_word(iss_pkg::OP_APPEND, -5, 32'hFFFF_FFFF);
    send_word(iss_pkg::OP_APPEND, 0, $urandom);
    send_word(iss_pkg::OP_APPEND, 7, $urandom);
    send_word(iss_pkg::OP_APPEND, 100, $urandom);
    send_word(iss_pkg::OP_APPEND, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(iss_pkg::OP_SEARCH, 32'sh8000_0000, 0);
    send_word(iss_pkg::OP_SEARCH, 32'sh7FFF_FFFF, 0);
    send_word(iss_pkg::OP_SEARCH, 7, 0);
    send_word(iss_pkg::OP_SEARCH, 8, 32'hFFFF_FFFF);
    send_word(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    configure(7'd4, ORD_UNORDERED);
    send_word(iss_pkg::OP_SEARCH, 7, 0);
    configure(7'd4, ORD_INVALID);
    send_word(iss_pkg::OP_SEARCH, 100, 0);
    configure(7'd3, iss_pkg::ORD_DESC);
    send_word(iss_pkg::OP_CLEAR, 0, 0);
    send_word(iss_pkg::OP_APPEND, 50, $urandom);
    send_word(iss_pkg::OP_APPEND, 20, $urandom);
    send_word(iss_pkg::OP_APPEND, -10, $urandom);
    send_word(iss_pkg::OP_SEARCH, 60, 0);
    send_word(iss_pkg::OP_SEARCH, 20, 0);
    send_word(iss_pkg::OP_SEARCH, -10, 0);
    send_word(iss_pkg::OP_SEARCH, -11, 0);
  endtask

  // page size zero acts as one, so the index fills after 256 records
  task automatic test_index_full();
    configure(7'd0, iss_pkg::ORD_ASC);
    send_word(iss_pkg::OP_CLEAR, 0, 0);
    for (int i = 0; i < INDEX_DEPTH + 4; i++)
      send_word(iss_pkg::OP_APPEND, i * 16 - 2048, $urandom);
    send_word(iss_pkg::OP_SEARCH, (INDEX_DEPTH - 1) * 16 - 2048, 0);
    send_word(iss_pkg::OP_SEARCH, (INDEX_DEPTH + 1) * 16 - 2048, 0);
    send_word(iss_pkg::OP_SEARCH, -4096, 0);
    repeat (8)
      send_word(iss_pkg::OP_SEARCH, $urandom_range(0, INDEX_DEPTH + 3) * 16 - 2048 +
                ($urandom_range(0, 3) == 0), 0);
  endtask

  task automatic test_store_full();
    configure(7'd127, iss_pkg::ORD_DESC);
    send_word(iss_pkg::OP_CLEAR, 0, 0);
    for (int i = 0; i < FILE_DEPTH + 4; i++)
      send_word(iss_pkg::OP_APPEND, 3_000_000 - 3 * i, $urandom);
    send_word(iss_pkg::OP_SEARCH, 3_000_000 - 3 * (FILE_DEPTH - 1), 0);
    send_word(iss_pkg::OP_SEARCH, 3_000_000 - 3 * (FILE_DEPTH + 1), 0);
    send_word(iss_pkg::OP_SEARCH, 3_000_001, 0);
    repeat (6) send_word(iss_pkg::OP_SEARCH, pick_key(), 0);
    // relayout with more pages than the index holds
    configure(7'd1, iss_pkg::ORD_DESC);
    send_word(iss_pkg::OP_SEARCH, 3_000_000 - 3 * 100, 0);
    send_word(iss_pkg::OP_SEARCH, 3_000_000 - 3 * (INDEX_DEPTH - 1), 0);
    send_word(iss_pkg::OP_SEARCH, 3_000_000 - 3 * INDEX_DEPTH, 0);
    send_word(iss_pkg::OP_SEARCH, 3_000_000 - 3 * 700, 0);
    // content against the configured order
    configure(7'd2, iss_pkg::ORD_ASC);
    repeat (6) send_word(iss_pkg::OP_SEARCH, pick_key(), 0);
  endtask

  task automatic test_random_files(input int budget);
    int         start;
    int         n;
    int         r;
    logic [6:0] ps;
    logic [1:0] ord;
    bit         fresh;
    start = words_sent;
    while (words_sent - start < budget) begin
      case ($urandom_range(0, 9))
        0:       ps = 7'd0;
        1:       ps = 7'd1;
        2:       ps = 7'd64;
        3:       ps = $urandom_range(65, 127);
        default: ps = $urandom_range(2, 16);
      endcase
      r   = $urandom_range(0, 19);
      ord = (r < 9) ? iss_pkg::ORD_ASC : (r < 18) ? iss_pkg::ORD_DESC :
            (r == 18) ? ORD_UNORDERED : ORD_INVALID;
      fresh = ($urandom_range(0, 4) != 0) || file_count == 0;
      configure(ps, ord);
      if (fresh) begin
        send_word(iss_pkg::OP_CLEAR, $urandom, $urandom);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
        append_run(n, ord == iss_pkg::ORD_DESC, $urandom_range(0, 9) == 0);
      end
      repeat ($urandom_range(5, 30)) begin
        if ($urandom_range(0, 24) == 0) send_word(OP_NOP, $urandom, $urandom);
        if ($urandom_range(0, 39) == 0) send_word(iss_pkg::OP_APPEND, $urandom, $urandom);
        send_word(iss_pkg::OP_SEARCH, pick_key(), $urandom);
      end
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_files(TAIL_WORDS);
  endtask

  initial begin : result_sink
    int            stall;
    iss_pkg::res_t got;
    iss_pkg::res_t want;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status  = m_axis_tuser;
        got.key     = m_axis_tdata[31:0];
        got.payload = m_axis_tdata[63:32];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word", got.key, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("search_status", 32'(got.status), 32'(want.status));
          if (got.key !== want.key) report_mismatch("found_key", got.key, want.key);
          if (got.payload !== want.payload)
            report_mismatch("found_payload", got.payload, want.payload);
          searches_checked++;
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, MAX_GAP - 1);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= iss_pkg::OP_CLEAR;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= iss_pkg::CFG_PAGE_SIZE;
    cfg_data_i    <= '0;
    cycles           = 0;
    mismatches       = 0;
    words_sent       = 0;
    searches_checked = 0;
    settings_used    = 0;
    idle_on          = 1'b1;
    file_count       = 0;
    page_size_reg    = 7'd8;
    order_reg        = iss_pkg::ORD_ASC;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_index_full();
    test_store_full();
    test_random_files(RANDOM_WORDS - TAIL_WORDS);
    test_steady_stream();
    wait_idle();

    $display("ran %0d words over %0d register settings, %0d search results checked",
             words_sent, settings_used, searches_checked);
    $display("edge keys, full index, full store, relayout and refused orders included");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL");
    end
    $finish;
  end

endmodule
